>>> rtl/mriu_pkg.sv
// ----------------------------------------------------------------------------
// mriu_pkg
// Shared constants and types for the linear index unflatten unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mriu_pkg;

  localparam int NUM_DIMS       = 6;
  localparam int RANK_BITS      = 3;
  localparam int REG_IDX_BITS   = 3;
  localparam int DEF_MAX_RANK   = 6;
  localparam int DEF_INDEX_BITS = 48;
  localparam int DEF_DIM_BITS   = 16;
  // quotient bits resolved per pipeline stage
  localparam int BITS_PER_STAGE = 4;

  localparam logic [REG_IDX_BITS-1:0] REG_RANK       = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_DIM_SIZE_0 = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_DIM_SIZE_5 = 3'd6;

  typedef struct packed {
    logic valid;
    logic err;
  } pipe_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/mixed_radix_index_unflatten_unit.sv
// ----------------------------------------------------------------------------
// mixed_radix_index_unflatten_unit
// Splits a row-major linear index into per-dimension coordinates.
//
// One input channel (in_valid/in_stall, linear_index) and one output channel
// (out_valid/out_stall, coord_0..coord_5, size_error), one result per beat.
// Configuration: wr_en/wr_index/wr_data write rank (index 0) and the six
// dimension sizes (indexes 1..6); write only while the unit is empty.
// Each dimension, innermost first, runs through a restoring divider chain
// of ceil(INDEX_BITS/4) stages, four quotient bits per stage, and one beat
// is accepted every cycle while the output is not stalled. Unused
// dimensions divide by one.
// A zero size in a used dimension raises size_error with zero coordinates.
// Reset empties the pipeline and sets rank and all sizes to 1.
// While the output beat is stalled, the whole pipeline holds and in_stall
// is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module mixed_radix_index_unflatten_unit #(
  parameter int MAX_RANK   = mriu_pkg::DEF_MAX_RANK,
  parameter int INDEX_BITS = mriu_pkg::DEF_INDEX_BITS,
  parameter int DIM_BITS   = mriu_pkg::DEF_DIM_BITS
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                wr_en,
  input  wire  [mriu_pkg::REG_IDX_BITS-1:0]  wr_index,
  input  wire  [DIM_BITS-1:0]                wr_data,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [INDEX_BITS-1:0]              linear_index,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [DIM_BITS-1:0]                coord_0,
  output logic [DIM_BITS-1:0]                coord_1,
  output logic [DIM_BITS-1:0]                coord_2,
  output logic [DIM_BITS-1:0]                coord_3,
  output logic [DIM_BITS-1:0]                coord_4,
  output logic [DIM_BITS-1:0]                coord_5,
  output logic                               size_error
);
  import mriu_pkg::*;

  localparam int ND = (MAX_RANK < NUM_DIMS) ? MAX_RANK : NUM_DIMS;

  logic [RANK_BITS-1:0]              rank;
  logic [NUM_DIMS-1:0][DIM_BITS-1:0] dim_size;
  logic [RANK_BITS-1:0]              rank_eff;
  logic [ND-1:0]                     used;
  logic [ND-1:0][DIM_BITS-1:0]       divisor;
  logic                              any_zero;
  logic                              en;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank <= RANK_BITS'(1);
      for (int k = 0; k < NUM_DIMS; k++) dim_size[k] <= DIM_BITS'(1);
    end else if (wr_en) begin
      if (wr_index == REG_RANK) begin
        rank <= wr_data[RANK_BITS-1:0];
      end else if (wr_index >= REG_DIM_SIZE_0 && wr_index <= REG_DIM_SIZE_5) begin
        dim_size[wr_index - REG_DIM_SIZE_0] <= wr_data;
      end
    end
  end

  assign rank_eff = (rank > RANK_BITS'(ND)) ? RANK_BITS'(ND) : rank;

  always_comb begin
    any_zero = 1'b0;
    for (int k = 0; k < ND; k++) begin
      used[k] = RANK_BITS'(k) < rank_eff;
      if (used[k] && dim_size[k] == '0) any_zero = 1'b1;
    end
    for (int k = 0; k < ND; k++) begin
      divisor[k] = (used[k] && !any_zero) ? dim_size[k] : DIM_BITS'(1);
    end
  end

  // hold everything while the output beat waits
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  pipe_ctrl_t                  ctrl   [ND+1];
  logic [INDEX_BITS-1:0]       quo    [ND+1];
  logic [ND-1:0][DIM_BITS-1:0] coords [ND+1];

  assign ctrl[0]   = '{valid: in_valid, err: any_zero};
  assign quo[0]    = linear_index;
  assign coords[0] = '0;

  // chain index j handles dimension ND-1-j, innermost first
  for (genvar j = 0; j < ND; j++) begin : g_dim
    mriu_dim #(
      .IB(INDEX_BITS), .DB(DIM_BITS), .ND(ND), .DIM(ND - 1 - j)
    ) u_dim (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .ctrl_in   (ctrl[j]),
      .quo_in    (quo[j]),
      .coords_in (coords[j]),
      .divisor   (divisor[ND-1-j]),
      .ctrl_out  (ctrl[j+1]),
      .quo_out   (quo[j+1]),
      .coords_out(coords[j+1])
    );
  end

  logic [NUM_DIMS-1:0][DIM_BITS-1:0] cfull;

  for (genvar k = 0; k < NUM_DIMS; k++) begin : g_pad
    if (k < ND) begin : g_used
      assign cfull[k] = ctrl[ND].err ? '0 : coords[ND][k];
    end else begin : g_none
      assign cfull[k] = '0;
    end
  end

  assign out_valid  = ctrl[ND].valid;
  assign size_error = ctrl[ND].err;
  assign coord_0    = cfull[0];
  assign coord_1    = cfull[1];
  assign coord_2    = cfull[2];
  assign coord_3    = cfull[3];
  assign coord_4    = cfull[4];
  assign coord_5    = cfull[5];

endmodule

`default_nettype wire

>>> rtl/mriu_div_step.sv
// ----------------------------------------------------------------------------
// mriu_div_step
// One register stage of a restoring divider: resolves NB quotient bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mriu_div_step #(
  parameter int IB    = 48,
  parameter int DB    = 16,
  parameter int ND    = 6,
  parameter int NB    = 4,
  parameter int DIM   = 0,
  parameter bit FIRST = 1'b0,
  parameter bit LAST  = 1'b0
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           en,
  input  wire mriu_pkg::pipe_ctrl_t     ctrl_in,
  input  wire  [IB-1:0]                 quo_in,
  input  wire  [DB-1:0]                 rem_in,
  input  wire  [ND-1:0][DB-1:0]         coords_in,
  input  wire  [DB-1:0]                 divisor,
  output mriu_pkg::pipe_ctrl_t          ctrl_out,
  output logic [IB-1:0]                 quo_out,
  output logic [DB-1:0]                 rem_out,
  output logic [ND-1:0][DB-1:0]         coords_out
);
  import mriu_pkg::*;

  logic [IB-1:0]         quo_next;
  logic [DB-1:0]         rem_next;
  logic [ND-1:0][DB-1:0] coords_next;

  always_comb begin
    logic [DB:0] t;
    logic [DB-1:0] r;
    logic [IB-1:0] q;
    r = FIRST ? '0 : rem_in;
    q = quo_in;
    for (int i = 0; i < NB; i++) begin
      t = {r, q[IB-1]};
      q = {q[IB-2:0], 1'b0};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
        q[0] = 1'b1;
      end
      r = t[DB-1:0];
    end
    quo_next = q;
    rem_next = r;
    coords_next = coords_in;
    // remainder after the last bit is this dimension's coordinate
    if (LAST) coords_next[DIM] = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else if (en) begin
      ctrl_out <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_out    <= quo_next;
      rem_out    <= rem_next;
      coords_out <= coords_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/mriu_dim.sv
// ----------------------------------------------------------------------------
// mriu_dim
// Divider chain for one dimension: quotient on, remainder into its coordinate.
// ----------------------------------------------------------------------------
`default_nettype none

module mriu_dim #(
  parameter int IB  = 48,
  parameter int DB  = 16,
  parameter int ND  = 6,
  parameter int DIM = 0
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       en,
  input  wire mriu_pkg::pipe_ctrl_t ctrl_in,
  input  wire  [IB-1:0]             quo_in,
  input  wire  [ND-1:0][DB-1:0]     coords_in,
  input  wire  [DB-1:0]             divisor,
  output mriu_pkg::pipe_ctrl_t      ctrl_out,
  output logic [IB-1:0]             quo_out,
  output logic [ND-1:0][DB-1:0]     coords_out
);
  import mriu_pkg::*;

  localparam int NS = (IB + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

  pipe_ctrl_t            ctrl   [NS+1];
  logic [IB-1:0]         quo    [NS+1];
  logic [DB-1:0]         rem    [NS+1];
  logic [ND-1:0][DB-1:0] coords [NS+1];

  assign ctrl[0]   = ctrl_in;
  assign quo[0]    = quo_in;
  assign rem[0]    = '0;
  assign coords[0] = coords_in;

  for (genvar s = 0; s < NS; s++) begin : g_step
    localparam int LEFT = IB - s * BITS_PER_STAGE;
    localparam int NB   = (LEFT < BITS_PER_STAGE) ? LEFT : BITS_PER_STAGE;
    mriu_div_step #(
      .IB(IB), .DB(DB), .ND(ND), .NB(NB), .DIM(DIM),
      .FIRST(s == 0), .LAST(s == NS - 1)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .ctrl_in   (ctrl[s]),
      .quo_in    (quo[s]),
      .rem_in    (rem[s]),
      .coords_in (coords[s]),
      .divisor   (divisor),
      .ctrl_out  (ctrl[s+1]),
      .quo_out   (quo[s+1]),
      .rem_out   (rem[s+1]),
      .coords_out(coords[s+1])
    );
  end

  assign ctrl_out   = ctrl[NS];
  assign quo_out    = quo[NS];
  assign coords_out = coords[NS];

endmodule

`default_nettype wire

>>> dv/unflatten_checker.sv
// ----------------------------------------------------------------------------
// unflatten_checker
// Watches both channels of the unflatten unit, predicts the coordinates of
// every accepted index from a shadow copy of the registers, and compares
// each output beat with the oldest prediction in order.
// ----------------------------------------------------------------------------
module unflatten_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [mriu_pkg::REG_IDX_BITS-1:0] wr_index,
  input  logic [15:0]                       wr_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [47:0]                       linear_index,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [15:0]                       coord_0,
  input  logic [15:0]                       coord_1,
  input  logic [15:0]                       coord_2,
  input  logic [15:0]                       coord_3,
  input  logic [15:0]                       coord_4,
  input  logic [15:0]                       coord_5,
  input  logic                              size_error,
  output int                                fail_count,
  output int                                pending
);
  import mriu_pkg::*;

  typedef struct packed {
    logic [5:0][15:0] coord;
    logic             err;
  } coords_t;

  logic [2:0]       shadow_rank;
  logic [5:0][15:0] shadow_size;
  coords_t          expected_coords[$];

  function automatic coords_t split_index(logic [47:0] idx);
    coords_t     res;
    logic [47:0] q;
    int          r;
    q = idx;
    res = '0;
    r = (shadow_rank > NUM_DIMS) ? NUM_DIMS : shadow_rank;
    for (int k = 0; k < r; k++)
      if (shadow_size[k] == 0) res.err = 1'b1;
    if (!res.err) begin
      for (int k = r - 1; k >= 0; k--) begin
        res.coord[k] = 16'(q % shadow_size[k]);
        q = q / shadow_size[k];
      end
    end
    return res;
  endfunction

  assign pending = expected_coords.size();

  always @(posedge clk) begin
    coords_t got, want;
    if (rst) begin
      shadow_rank <= 3'd1;
      for (int k = 0; k < NUM_DIMS; k++) shadow_size[k] <= 16'd1;
      fail_count <= 0;
    end else begin
      if (wr_en) begin
        if (wr_index == REG_RANK) shadow_rank <= wr_data[2:0];
        else if (wr_index >= REG_DIM_SIZE_0 && wr_index <= REG_DIM_SIZE_5)
          shadow_size[wr_index - REG_DIM_SIZE_0] <= wr_data;
      end
      if (in_valid && !in_stall) expected_coords.push_back(split_index(linear_index));
      if (out_valid && !out_stall) begin
        got.coord = {coord_5, coord_4, coord_3, coord_2, coord_1, coord_0};
        got.err = size_error;
        if (expected_coords.size() == 0) begin
          if (fail_count < 10) $display("unexpected beat %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_coords.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("mismatch: exp coords %h err %b, got coords %h err %b",
                       want.coord, want.err, got.coord, got.err);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives indices in bursts through several shapes of tensor, stalls the
// output on its own pattern, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
  import mriu_pkg::*;

  localparam int LATENCY = 72;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    wr_en = 1'b0;
  logic [REG_IDX_BITS-1:0] wr_index = REG_RANK;
  logic [15:0]             wr_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [47:0]             linear_index = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [15:0]             coord_0, coord_1, coord_2, coord_3, coord_4, coord_5;
  logic                    size_error;
  int                      fail_count, pending;
  bit                      stall_on = 1'b0;

  always #5 clk = ~clk;

  mixed_radix_index_unflatten_unit uut (.*);
  unflatten_checker chk (.*);

  // receiver: random stalls, some phases clean
  always @(posedge clk) begin
    if (!stall_on) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, logic [15:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic set_shape(int r, logic [15:0] s0, logic [15:0] s1, logic [15:0] s2,
                           logic [15:0] s3, logic [15:0] s4, logic [15:0] s5);
    write_reg(REG_RANK, 16'(r));
    write_reg(REG_DIM_SIZE_0, s0);
    write_reg(REG_DIM_SIZE_0 + 3'd1, s1);
    write_reg(REG_DIM_SIZE_0 + 3'd2, s2);
    write_reg(REG_DIM_SIZE_0 + 3'd3, s3);
    write_reg(REG_DIM_SIZE_0 + 3'd4, s4);
    write_reg(REG_DIM_SIZE_5, s5);
  endtask

  // hold valid until accepted; keep it high if the next beat follows at once
  task automatic send_index(logic [47:0] idx);
    in_valid <= 1'b1;
    linear_index <= idx;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  function automatic logic [47:0] rand_index();
    case ($urandom_range(0, 3))
      0: return 48'($urandom_range(0, 255));
      1: return '1 - 48'($urandom_range(0, 15));
      default: return {16'($urandom), 32'($urandom)};
    endcase
  endfunction

  task automatic random_phase(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && n > 0; i++, n--) send_index(rand_index());
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_size();
    case ($urandom_range(0, 5))
      0: return 16'hFFFF;
      1: return 16'd1;
      2: return 16'($urandom_range(0, 1) ? 0 : 2);
      default: return 16'($urandom_range(2, 300));
    endcase
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: index extremes at reset shape, then a 4x3x2 tensor with wrap
    send_index('0);
    send_index('1);
    send_index(48'h5555_5555_5555);
    send_index(48'hAAAA_AAAA_AAAA);
    in_valid <= 1'b0;
    drain();
    set_shape(3, 16'd4, 16'd3, 16'd2, 16'd9, 16'd9, 16'd9);
    for (int i = 0; i < 8; i++) send_index(48'(i * 5));
    send_index(48'd24);
    send_index('1);
    in_valid <= 1'b0;
    drain();
    // rank zero, rank above the dimension count, zero size in a used dimension
    set_shape(0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_index('1);
    in_valid <= 1'b0;
    drain();
    set_shape(7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_index('1);
    send_index(48'h1234_5678_9ABC);
    in_valid <= 1'b0;
    drain();
    set_shape(2, 16'd5, 16'd0, 16'd3, 16'd3, 16'd3, 16'd3);
    send_index(48'd17);
    in_valid <= 1'b0;
    drain();
    // write to a register index past the list is ignored
    write_reg(3'd7, 16'hFFFF);

    for (int ph = 0; ph < 12; ph++) begin
      stall_on = (ph % 3 != 0);
      set_shape($urandom_range(0, 7), rand_size(), rand_size(), rand_size(),
                rand_size(), rand_size(), rand_size());
      random_phase(104);
      drain();
    end

    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> filelist.f
rtl/mriu_pkg.sv
rtl/mriu_div_step.sv
rtl/mriu_dim.sv
rtl/mixed_radix_index_unflatten_unit.sv
dv/unflatten_checker.sv
dv/testbench.sv
